/* sv/nfa_pkg.sv */
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared types, command and status codes and default geometry for the
// NAND flash array model.
// ----------------------------------------------------------------------------
package nfa_pkg;

    // default geometry
    localparam int PAGE_BYTES_DEF      = 512;
    localparam int PAGES_PER_BLOCK_DEF = 16;
    localparam int BLOCKS_DEF          = 32;

    // field widths
    localparam int CMD_W    = 3;
    localparam int PAGE_W   = 12;
    localparam int BLOCK_W  = 8;
    localparam int INDEX_W  = 9;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int WEAR_W   = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PROGRAM  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK_BAD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;
    localparam logic [WEAR_W-1:0] WEAR_MAX    = 16'hFFFF;

    // request item
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [PAGE_W-1:0]  page;
        logic [BLOCK_W-1:0] block;
        logic [INDEX_W-1:0] byte_index;
        logic [DATA_W-1:0]  write_data;
    } nfa_req_t;

    // response item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_data;
        logic                block_bad;
        logic [WEAR_W-1:0]   wear_count;
    } nfa_rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic latch;
        logic decode;
        logic check;
        logic cell_wr;
        logic fill_step;
        logic mark_set;
        logic erase_step;
        logic clear_step;
        logic wear_inc;
        logic set_bad;
        logic sweep_rst;
        logic rsp_load;
    } nfa_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ok;
        logic             marked;
        logic             clear_last;
        logic             fill_last;
        logic             erase_last;
    } nfa_sts_t;

endpackage

/* sv/nfa_ctrl.sv */
// ----------------------------------------------------------------------------
// nfa_ctrl
// Sequencer for the flash array model: reset clearing pass, per-command
// decode/check/execute steps, page fill and block erase walks, and the
// response register handshake.
// ----------------------------------------------------------------------------
module nfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output nfa_pkg::nfa_ctl_t ctl,
    input  nfa_pkg::nfa_sts_t sts
);
    import nfa_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_EXEC   = 3'd4;
    localparam logic [2:0] S_FILL   = 3'd5;
    localparam logic [2:0] S_ERASE  = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       rsp_free;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // state sequencing and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.decode = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ctl.check  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                if (sts.ok)
                begin
                    case (sts.cmd)
                        CMD_PROGRAM:
                        begin
                            if (sts.marked)
                            begin
                                ctl.cell_wr = 1'b1;
                            end
                            else
                            begin
                                ctl.sweep_rst = 1'b1;
                                state_next    = S_FILL;
                            end
                        end
                        CMD_ERASE:
                        begin
                            ctl.wear_inc  = 1'b1;
                            ctl.sweep_rst = 1'b1;
                            state_next    = S_ERASE;
                        end
                        CMD_MARK_BAD:
                        begin
                            ctl.set_bad = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                ctl.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    ctl.mark_set = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_ERASE:
            begin
                ctl.erase_step = 1'b1;
                if (sts.erase_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    ctl.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // response valid flag
    always_comb
    begin
        if (ctl.rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

/* sv/nfa_datapath.sv */
// ----------------------------------------------------------------------------
// nfa_datapath
// Address arithmetic, range and bad block checks, cell, page mark and wear
// counter memories, bad block marks and the response register.
// A page whose mark is clear reads as erased; its cells are filled on the
// first program after reset or an erase.
// ----------------------------------------------------------------------------
module nfa_datapath #(
    parameter int PAGE_BYTES      = nfa_pkg::PAGE_BYTES_DEF,
    parameter int PAGES_PER_BLOCK = nfa_pkg::PAGES_PER_BLOCK_DEF,
    parameter int BLOCKS          = nfa_pkg::BLOCKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nfa_pkg::nfa_req_t req_data,
    input  nfa_pkg::nfa_ctl_t ctl,
    output nfa_pkg::nfa_sts_t sts,
    output nfa_pkg::nfa_rsp_t rsp_data
);
    import nfa_pkg::*;

    localparam int TOTAL_PAGES = BLOCKS * PAGES_PER_BLOCK;
    localparam int CELLS       = TOTAL_PAGES * PAGE_BYTES;
    localparam int PG_W        = $clog2(TOTAL_PAGES);
    localparam int BLK_W       = $clog2(BLOCKS);
    localparam int OFF_W       = $clog2(PAGE_BYTES);
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int SWEEP_MAX   = (TOTAL_PAGES > PAGE_BYTES) ? TOTAL_PAGES : PAGE_BYTES;
    localparam int SW_W        = $clog2(SWEEP_MAX);
    // page to block by reciprocal multiply, exact for every page code
    localparam int RECIP_SH    = PAGE_W + $clog2(PAGES_PER_BLOCK);
    localparam int RECIP       = ((1 << RECIP_SH) + PAGES_PER_BLOCK - 1) / PAGES_PER_BLOCK;
    localparam int RECIP_W     = PAGE_W + 2;
    localparam int PROD_W      = PAGE_W + RECIP_W;

    // memories
    logic [DATA_W-1:0] cell_mem [CELLS];
    logic              mark_mem [TOTAL_PAGES];
    logic [WEAR_W-1:0] wear_mem [BLOCKS];
    logic              bad_reg  [BLOCKS];

    nfa_req_t          item_reg;
    nfa_rsp_t          rsp_reg;
    nfa_rsp_t          rsp_next;

    // decode stage registers
    logic              pg_err_reg;
    logic              blk_err_reg;
    logic [BLK_W-1:0]  page_blk_reg;
    logic [ADDR_W-1:0] page_base_reg;
    logic [ADDR_W-1:0] cell_addr_reg;
    logic [PG_W-1:0]   pidx_reg;
    logic [PG_W-1:0]   first_pg_reg;
    logic [BLK_W-1:0]  cblk_reg;
    logic [OFF_W-1:0]  off_reg;

    // check stage registers
    logic [STATUS_W-1:0] stat_reg;
    logic                qbad_reg;
    logic                mark_rd_reg;
    logic [DATA_W-1:0]   cell_rd_reg;
    logic [WEAR_W-1:0]   wear_rd_reg;

    logic [SW_W-1:0]     sweep_reg;
    logic [SW_W-1:0]     sweep_next;

    logic [PROD_W-1:0]   blk_prod;
    logic [ADDR_W-1:0]   page_base;
    logic                page_op;
    logic [BLK_W-1:0]    bad_idx;
    logic                bad_hit;
    logic [STATUS_W-1:0] stat;

    logic                cell_we;
    logic [ADDR_W-1:0]   cell_wa;
    logic [DATA_W-1:0]   cell_wd;
    logic                mark_we;
    logic [PG_W-1:0]     mark_wa;
    logic                wear_we;
    logic [BLK_W-1:0]    wear_wa;
    logic [WEAR_W-1:0]   wear_wd;

    // request capture
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            item_reg <= req_data;
        end
    end

    // address arithmetic and range checks
    assign blk_prod  = PROD_W'(item_reg.page) * PROD_W'(RECIP);
    assign page_base = ADDR_W'(32'(item_reg.page) * 32'(PAGE_BYTES));

    always_ff @(posedge clk)
    begin
        if (ctl.decode)
        begin
            pg_err_reg    <= (32'(item_reg.page) >= 32'(TOTAL_PAGES)) ||
                             (32'(item_reg.byte_index) >= 32'(PAGE_BYTES));
            blk_err_reg   <= (32'(item_reg.block) >= 32'(BLOCKS));
            page_blk_reg  <= BLK_W'(blk_prod >> RECIP_SH);
            page_base_reg <= page_base;
            cell_addr_reg <= page_base + ADDR_W'(item_reg.byte_index);
            pidx_reg      <= PG_W'(item_reg.page);
            first_pg_reg  <= PG_W'(32'(item_reg.block) * 32'(PAGES_PER_BLOCK));
            cblk_reg      <= BLK_W'(item_reg.block);
            off_reg       <= OFF_W'(item_reg.byte_index);
        end
    end

    // status selection from range and bad mark
    always_comb
    begin
        page_op = (item_reg.cmd == CMD_READ) || (item_reg.cmd == CMD_PROGRAM);
        bad_idx = page_op ? page_blk_reg : cblk_reg;
        bad_hit = bad_reg[bad_idx];
        case (item_reg.cmd) inside
            CMD_READ, CMD_PROGRAM:
            begin
                stat = pg_err_reg ? ST_RANGE : (bad_hit ? ST_BAD : ST_OK);
            end
            CMD_ERASE:
            begin
                stat = blk_err_reg ? ST_RANGE : (bad_hit ? ST_BAD : ST_OK);
            end
            CMD_MARK_BAD, CMD_QUERY:
            begin
                stat = blk_err_reg ? ST_RANGE : ST_OK;
            end
            default:
            begin
                stat = ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.check)
        begin
            stat_reg <= stat;
            qbad_reg <= blk_err_reg ? 1'b1 : bad_hit;
        end
    end

    // sweep counter for clearing pass, page fill and erase walk
    always_comb
    begin
        if (ctl.sweep_rst)
        begin
            sweep_next = '0;
        end
        else if (ctl.clear_step || ctl.fill_step || ctl.erase_step)
        begin
            sweep_next = sweep_reg + SW_W'(1);
        end
        else
        begin
            sweep_next = sweep_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else
        begin
            sweep_reg <= sweep_next;
        end
    end

    // cell memory write port
    always_comb
    begin
        cell_we = ctl.cell_wr || ctl.fill_step;
        if (ctl.fill_step)
        begin
            cell_wa = page_base_reg + ADDR_W'(sweep_reg);
            cell_wd = (OFF_W'(sweep_reg) == off_reg) ? item_reg.write_data : ERASED_BYTE;
        end
        else
        begin
            cell_wa = cell_addr_reg;
            cell_wd = item_reg.write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_wa] <= cell_wd;
        end
        if (ctl.check)
        begin
            cell_rd_reg <= cell_mem[cell_addr_reg];
        end
    end

    // page mark memory
    always_comb
    begin
        mark_we = ctl.clear_step || ctl.erase_step || ctl.mark_set;
        if (ctl.mark_set)
        begin
            mark_wa = pidx_reg;
        end
        else if (ctl.erase_step)
        begin
            mark_wa = first_pg_reg + PG_W'(sweep_reg);
        end
        else
        begin
            mark_wa = PG_W'(sweep_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wa] <= ctl.mark_set;
        end
        if (ctl.check)
        begin
            mark_rd_reg <= mark_mem[pidx_reg];
        end
    end

    // wear counter memory, saturating increment
    always_comb
    begin
        wear_we = ctl.wear_inc || (ctl.clear_step && (32'(sweep_reg) < 32'(BLOCKS)));
        if (ctl.clear_step)
        begin
            wear_wa = BLK_W'(sweep_reg);
            wear_wd = '0;
        end
        else
        begin
            wear_wa = cblk_reg;
            wear_wd = (wear_rd_reg == WEAR_MAX) ? WEAR_MAX : wear_rd_reg + WEAR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wear_we)
        begin
            wear_mem[wear_wa] <= wear_wd;
        end
        if (ctl.check)
        begin
            wear_rd_reg <= wear_mem[cblk_reg];
        end
    end

    // bad block marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BLOCKS; i++)
            begin
                bad_reg[i] <= 1'b0;
            end
        end
        else if (ctl.set_bad)
        begin
            bad_reg[cblk_reg] <= 1'b1;
        end
    end

    // response assembly
    always_comb
    begin
        rsp_next.status     = stat_reg;
        rsp_next.read_data  = '0;
        rsp_next.block_bad  = 1'b0;
        rsp_next.wear_count = '0;
        if ((item_reg.cmd == CMD_READ) && (stat_reg == ST_OK))
        begin
            rsp_next.read_data = mark_rd_reg ? cell_rd_reg : ERASED_BYTE;
        end
        if (item_reg.cmd == CMD_QUERY)
        begin
            rsp_next.block_bad = qbad_reg;
            if (stat_reg == ST_OK)
            begin
                rsp_next.wear_count = wear_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_data = rsp_reg;

    // status back to the controller
    assign sts.cmd        = item_reg.cmd;
    assign sts.ok         = (stat_reg == ST_OK);
    assign sts.marked     = mark_rd_reg;
    assign sts.clear_last = (sweep_reg == SW_W'(TOTAL_PAGES - 1));
    assign sts.fill_last  = (sweep_reg == SW_W'(PAGE_BYTES - 1));
    assign sts.erase_last = (sweep_reg == SW_W'(PAGES_PER_BLOCK - 1));

endmodule

/* sv/nand_flash_array_model_unit.sv */
// ----------------------------------------------------------------------------
// nand_flash_array_model_unit
// NAND flash array model with page and block structure, one byte per
// command: read, program, erase block, mark bad and query block.
// ----------------------------------------------------------------------------
// Usage
//   Request channel req_valid/req_stall/req_data carries one command; it is
//   taken on an edge with req_valid high and req_stall low. Each command
//   gives exactly one response on rsp_valid/rsp_stall/rsp_data.
//   Read, query, mark bad, program of an already programmed page and any
//   rejected command pass through the decode, check, execute and response
//   states; the response is registered as the sequencer leaves the last one.
//   The first program of a page after reset or erase fills that page, one
//   byte a cycle, through the cell memory write port.
//   Erase walks the block's page marks, one a cycle.
//   After reset the page mark and wear counter memories are cleared, one
//   entry a cycle; req_stall stays high meanwhile. Bad marks clear at once.
//   The response register frees the sequencer: a new request is taken
//   while a response still waits under rsp_stall; the following response
//   waits in the sequencer until the register is free.
// ----------------------------------------------------------------------------
module nand_flash_array_model_unit #(
    parameter int PAGE_BYTES      = nfa_pkg::PAGE_BYTES_DEF,
    parameter int PAGES_PER_BLOCK = nfa_pkg::PAGES_PER_BLOCK_DEF,
    parameter int BLOCKS          = nfa_pkg::BLOCKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  nfa_pkg::nfa_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output nfa_pkg::nfa_rsp_t rsp_data
);
    import nfa_pkg::*;

    nfa_ctl_t ctl;
    nfa_sts_t sts;

    // sequencer
    nfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    // storage and arithmetic
    nfa_datapath #(
        .PAGE_BYTES      (PAGE_BYTES),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
        .BLOCKS          (BLOCKS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .ctl      (ctl),
        .sts      (sts),
        .rsp_data (rsp_data)
    );

endmodule

/* tb/nand_flash_array_model_unit_tb.sv */
// ----------------------------------------------------------------------------
// nand_flash_array_model_unit_tb
// Self-checking bench for the NAND flash array model. Every accepted
// command goes through a cycle-free predictor of the array, pages, bad
// marks and wear counters; each response is checked field by field
// against the oldest prediction. A short directed run is followed by
// random traffic under three idling profiles on both channels.
// ----------------------------------------------------------------------------
module nand_flash_array_model_unit_tb;

    import nfa_pkg::*;

    localparam int TOTAL_PAGES     = BLOCKS_DEF * PAGES_PER_BLOCK_DEF;
    localparam int CELL_COUNT      = TOTAL_PAGES * PAGE_BYTES_DEF;
    localparam int HOT_BLOCKS      = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int SETTLE_CYCLES   = 20;
    localparam int LOG_CAP         = 40;

    // command codes with no meaning in the block
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam int               UNUSED_CODES  = 3;

    // ------------------------------------------------------------------------
    // predictor of the flash array and store of expected responses
    // ------------------------------------------------------------------------
    class flash_scoreboard;
        logic [DATA_W-1:0] cells [CELL_COUNT];
        bit                page_written [TOTAL_PAGES];
        bit                bad_marks [BLOCKS_DEF];
        logic [WEAR_W-1:0] wear_counts [BLOCKS_DEF];
        nfa_rsp_t          expected_rsp [$];
        int                mismatches;
        int                rsp_seen;
        int                cmd_seen [8];

        function new();
            foreach (cells[i]) cells[i] = ERASED_BYTE;
            foreach (page_written[i]) page_written[i] = 1'b0;
            foreach (bad_marks[i]) bad_marks[i] = 1'b0;
            foreach (wear_counts[i]) wear_counts[i] = '0;
            foreach (cmd_seen[i]) cmd_seen[i] = 0;
            mismatches = 0;
            rsp_seen   = 0;
        endfunction

        // apply one command to the array copy and give its response
        function nfa_rsp_t predict_response(nfa_req_t r);
            nfa_rsp_t rsp;
            int       pg;
            int       blk;
            int       base;
            rsp = '0;
            rsp.status = ST_OK;
            pg  = int'(r.page);
            blk = int'(r.block);
            case (r.cmd) inside
                CMD_READ, CMD_PROGRAM:
                begin
                    if (pg >= TOTAL_PAGES || r.byte_index >= PAGE_BYTES_DEF)
                        rsp.status = ST_RANGE;
                    else if (bad_marks[pg / PAGES_PER_BLOCK_DEF])
                        rsp.status = ST_BAD;
                    else if (r.cmd == CMD_READ)
                        rsp.read_data = cells[pg * PAGE_BYTES_DEF + r.byte_index];
                    else
                    begin
                        cells[pg * PAGE_BYTES_DEF + r.byte_index] = r.write_data;
                        page_written[pg] = 1'b1;
                    end
                end
                CMD_ERASE:
                begin
                    if (blk >= BLOCKS_DEF)
                        rsp.status = ST_RANGE;
                    else if (bad_marks[blk])
                        rsp.status = ST_BAD;
                    else
                    begin
                        base = blk * PAGES_PER_BLOCK_DEF;
                        for (int p = 0; p < PAGES_PER_BLOCK_DEF; p++)
                            page_written[base + p] = 1'b0;
                        for (int b = 0; b < PAGES_PER_BLOCK_DEF * PAGE_BYTES_DEF; b++)
                            cells[base * PAGE_BYTES_DEF + b] = ERASED_BYTE;
                        // wear counter holds at its ceiling
                        if (wear_counts[blk] != WEAR_MAX)
                            wear_counts[blk] = wear_counts[blk] + 1'b1;
                    end
                end
                CMD_MARK_BAD:
                begin
                    if (blk >= BLOCKS_DEF)
                        rsp.status = ST_RANGE;
                    else
                        bad_marks[blk] = 1'b1;
                end
                CMD_QUERY:
                begin
                    // an absent block reads as bad
                    if (blk >= BLOCKS_DEF)
                    begin
                        rsp.status    = ST_RANGE;
                        rsp.block_bad = 1'b1;
                    end
                    else
                    begin
                        rsp.block_bad  = bad_marks[blk];
                        rsp.wear_count = wear_counts[blk];
                    end
                end
                default:
                    rsp.status = ST_RANGE;
            endcase
            return rsp;
        endfunction

        function void note_command(nfa_req_t r);
            cmd_seen[r.cmd]++;
            expected_rsp.push_back(predict_response(r));
        endfunction

        function int outstanding();
            return expected_rsp.size();
        endfunction

        task report_mismatch(string what);
            // keep the log short on a badly broken block
            if (mismatches < LOG_CAP)
                $display("[%0t] mismatch on response %0d: %s", $time, rsp_seen, what);
            mismatches++;
        endtask

        task check_response(nfa_rsp_t got);
            nfa_rsp_t want;
            rsp_seen++;
            if (expected_rsp.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response %h", got));
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, predicted %0d",
                                          got.status, want.status));
            if (got.read_data !== want.read_data)
                report_mismatch($sformatf("read_data %h, predicted %h",
                                          got.read_data, want.read_data));
            if (got.block_bad !== want.block_bad)
                report_mismatch($sformatf("block_bad %b, predicted %b",
                                          got.block_bad, want.block_bad));
            if (got.wear_count !== want.wear_count)
                report_mismatch($sformatf("wear_count %0d, predicted %0d",
                                          got.wear_count, want.wear_count));
        endtask
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    nfa_req_t req_data  = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    nfa_rsp_t rsp_data;

    int tx_idle_pct = 36;
    int rx_idle_pct = 66;

    flash_scoreboard sb = new();

    nand_flash_array_model_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #16000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // response side: check each transfer, then choose the next stall
    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_response(rsp_data);
        rsp_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
    end

    // one request transfer, with an optional idle gap ahead of it
    task drive_command(input nfa_req_t item);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        req_data  <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        sb.note_command(item);
    endtask

    task send_cmd(input logic [CMD_W-1:0] cmd, input int pg, input int blk,
                  input int idx, input int wdata);
        nfa_req_t item;
        item.cmd        = cmd;
        item.page       = PAGE_W'(pg);
        item.block      = BLOCK_W'(blk);
        item.byte_index = INDEX_W'(idx);
        item.write_data = DATA_W'(wdata);
        drive_command(item);
    endtask

    // hold requests back until every response is in
    task wait_drained();
        req_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // random command, mostly on a few hot blocks so reads hit written data
    function automatic nfa_req_t random_request();
        nfa_req_t r;
        int       pick;
        r.cmd        = CMD_W'($urandom_range(4));
        r.page       = PAGE_W'($urandom_range(4095));
        r.block      = BLOCK_W'($urandom_range(255));
        r.byte_index = INDEX_W'($urandom_range(511));
        r.write_data = DATA_W'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 75)
        begin
            r.cmd  = (pick < 40) ? CMD_READ : CMD_PROGRAM;
            r.page = PAGE_W'($urandom_range(HOT_BLOCKS - 1) * PAGES_PER_BLOCK_DEF
                             + $urandom_range(PAGES_PER_BLOCK_DEF - 1));
            if ($urandom_range(1))
                r.byte_index = INDEX_W'($urandom_range(7));
        end
        else if (pick < 81)
        begin
            r.cmd = CMD_ERASE;
            if ($urandom_range(3) != 0)
                r.block = BLOCK_W'($urandom_range(HOT_BLOCKS - 1));
        end
        else if (pick < 89)
        begin
            r.cmd = CMD_QUERY;
            if ($urandom_range(3) != 0)
                r.block = BLOCK_W'($urandom_range(BLOCKS_DEF - 1));
        end
        else if (pick < 91)
        begin
            // bad marks stay away from the hot blocks
            r.cmd = CMD_MARK_BAD;
            r.block = BLOCK_W'($urandom_range(1)
                               ? $urandom_range(BLOCKS_DEF - 1, BLOCKS_DEF - 6)
                               : $urandom_range(255, BLOCKS_DEF));
        end
        else if (pick < 95)
            r.cmd = CMD_W'(CMD_UNUSED_LO + $urandom_range(UNUSED_CODES - 1));
        else if (r.cmd == CMD_MARK_BAD)
            r.cmd = CMD_QUERY;
        return r;
    endfunction

    task run_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            drive_command(random_request());
            if (n == count / 2)
                wait_drained();
        end
    endtask

    // directed corners of the command set
    task run_directed();
        int last_page;
        last_page = TOTAL_PAGES - 1;
        send_cmd(CMD_READ, 0, 0, 0, 0);
        send_cmd(CMD_PROGRAM, 0, 0, 0, 'h00);
        send_cmd(CMD_READ, 0, 0, 0, 0);
        send_cmd(CMD_PROGRAM, 0, 0, PAGE_BYTES_DEF - 1, 'hA5);
        send_cmd(CMD_READ, 0, 0, PAGE_BYTES_DEF - 1, 0);
        send_cmd(CMD_PROGRAM, last_page, 0, PAGE_BYTES_DEF - 1, 'hFF);
        send_cmd(CMD_READ, last_page, 0, PAGE_BYTES_DEF - 1, 0);
        // pages past the array
        send_cmd(CMD_READ, TOTAL_PAGES, 0, 0, 0);
        send_cmd(CMD_PROGRAM, 4095, 255, 511, 'h3C);
        send_cmd(CMD_QUERY, 0, 0, 0, 0);
        send_cmd(CMD_ERASE, 0, 0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 0, 0);
        send_cmd(CMD_QUERY, 0, 0, 0, 0);
        // blocks past the array
        send_cmd(CMD_ERASE, 0, 255, 0, 0);
        send_cmd(CMD_MARK_BAD, 0, BLOCKS_DEF, 0, 0);
        send_cmd(CMD_QUERY, 0, 255, 0, 0);
        // last block goes bad, twice over
        send_cmd(CMD_MARK_BAD, 0, BLOCKS_DEF - 1, 0, 0);
        send_cmd(CMD_MARK_BAD, 0, BLOCKS_DEF - 1, 0, 0);
        send_cmd(CMD_QUERY, 0, BLOCKS_DEF - 1, 0, 0);
        send_cmd(CMD_READ, last_page, 0, PAGE_BYTES_DEF - 1, 0);
        send_cmd(CMD_PROGRAM, last_page - 1, 0, 0, 'h11);
        send_cmd(CMD_ERASE, 0, BLOCKS_DEF - 1, 0, 0);
        // undefined command codes
        for (int u = 0; u < UNUSED_CODES; u++)
            send_cmd(CMD_W'(CMD_UNUSED_LO + u), 4095, 255, 511, 'hFF);
    endtask

    // stimulus and end of run
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        tx_idle_pct = 66;
        rx_idle_pct = 36;
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(ITEMS_PER_PHASE);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.outstanding() != 0)
            sb.report_mismatch($sformatf("%0d responses never came", sb.outstanding()));

        // wear saturation would need 65535 erases of one block, out of reach here
        $display("covered %0d reads, %0d programs, %0d erases, %0d bad marks, %0d queries",
                 sb.cmd_seen[CMD_READ], sb.cmd_seen[CMD_PROGRAM], sb.cmd_seen[CMD_ERASE],
                 sb.cmd_seen[CMD_MARK_BAD], sb.cmd_seen[CMD_QUERY]);
        $display("and %0d undefined codes, %0d responses checked over three idling profiles",
                 sb.cmd_seen[CMD_UNUSED_LO] + sb.cmd_seen[CMD_UNUSED_LO + 3'd1]
                 + sb.cmd_seen[CMD_UNUSED_LO + 3'd2], sb.rsp_seen);

        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
